// File: design/utx_pkg.sv
// Package for the 8E1 serial transmitter: shared types and fixed constants.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package utx_pkg;

  // Width of the bit period register and configuration data word, and of a data byte.
  localparam int unsigned PeriodW = 16;
  localparam int unsigned DataW   = 8;
  // Eight data bits, parity and one stop bit; further stop bits are shifted in as ones.
  localparam int unsigned ShiftW  = DataW + 2;

  localparam logic [PeriodW-1:0] PeriodReset = 16'd138;

  // Queues between the parts of the block.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam int unsigned CfgIndexW = 1;

  typedef enum logic [CfgIndexW-1:0] {
    CfgBitPeriod    = 1'b0,
    CfgLinkAttached = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PeriodW-1:0] bit_period;
    logic               link_attached;
  } cfg_t;

  // One tick as classified by the front end.
  typedef struct packed {
    logic             req;
    logic             parity;
    logic [DataW-1:0] data;
  } item_t;

  // One result of a tick.
  typedef struct packed {
    logic line;
    logic busy;
    logic accepted;
  } result_t;

endpackage

`default_nettype wire

// File: design/utx_front.sv
// Front end of the 8E1 transmitter: input queue that takes ticks and computes parity.
// Depends on utx_pkg for the item type and queue sizes.
`default_nettype none

module utx_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      send_request_i,
  input  logic [utx_pkg::DataW-1:0] send_byte_i,
  output logic                      item_valid_o,
  output utx_pkg::item_t            item_o,
  input  logic                      item_ready_i
);

  utx_pkg::item_t                 mem_q [utx_pkg::QDepth];
  logic [utx_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [utx_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [utx_pkg::QCntW-1:0]      count_q, count_d;
  logic                           do_push, do_pop;
  utx_pkg::item_t                 new_item;

  assign full         = (count_q == utx_pkg::QCntW'(utx_pkg::QDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_valid_o && item_ready_i;

  // Parity is worked out once here so the back end only shifts.
  always_comb begin
    new_item.req    = send_request_i;
    new_item.data   = send_byte_i;
    new_item.parity = ^send_byte_i;
  end

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: design/utx_engine.sv
// Back end of the 8E1 transmitter: bit timer, frame shifter and line register.
// Depends on utx_pkg for the configuration, item and result types.
`default_nettype none

module utx_engine #(
  parameter int unsigned FRAME_BITS = 11,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  utx_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  input  utx_pkg::item_t   item_i,
  output logic             item_ready_o,
  output logic             res_valid_o,
  output utx_pkg::result_t res_o,
  input  logic             res_ready_i
);

  localparam int unsigned BitsW = $clog2(FRAME_BITS + 1);
  localparam int unsigned WideW = TICK_WIDTH + utx_pkg::PeriodW;

  logic [utx_pkg::ShiftW-1:0]  shift_q, shift_d;
  logic [BitsW-1:0]            bits_q, bits_d;
  logic [TICK_WIDTH-1:0]       tick_q, tick_d;
  logic                        line_q, line_d;

  logic                        fire, busy;
  logic [BitsW-1:0]            bits_dec;
  logic [utx_pkg::PeriodW-1:0] period_m1;
  logic [WideW-1:0]            period_wide;
  logic [TICK_WIDTH-1:0]       reload;

  assign item_ready_o = res_ready_i;
  assign res_valid_o  = item_valid_i;
  assign fire         = item_valid_i && res_ready_i;
  assign busy         = (bits_q != '0);
  assign bits_dec     = bits_q - 1'b1;

  // A period of zero behaves as one; a reload too large for the timer saturates.
  assign period_m1   = (cfg_i.bit_period == '0) ? '0 : cfg_i.bit_period - 1'b1;
  assign period_wide = WideW'(period_m1);
  assign reload      = (|(period_wide >> TICK_WIDTH)) ? '1 : period_wide[TICK_WIDTH-1:0];

  // The result shows the state before this tick's update.
  always_comb begin
    res_o.line     = line_q;
    res_o.busy     = busy;
    res_o.accepted = !busy && item_i.req;
  end

  always_comb begin
    shift_d = shift_q;
    bits_d  = bits_q;
    tick_d  = tick_q;
    line_d  = line_q;
    if (fire) begin
      if (busy) begin
        if (tick_q != '0) begin
          tick_d = tick_q - 1'b1;
        end else begin
          bits_d = bits_dec;
          if (bits_dec != '0) begin
            line_d  = shift_q[0];
            shift_d = {1'b1, shift_q[utx_pkg::ShiftW-1:1]};
            tick_d  = reload;
          end else begin
            line_d = 1'b1;
          end
        end
      end else if (item_i.req && cfg_i.link_attached) begin
        // The start bit goes out at once; the rest of the frame waits in the shifter.
        line_d  = 1'b0;
        shift_d = {1'b1, item_i.parity, item_i.data};
        bits_d  = BitsW'(FRAME_BITS);
        tick_d  = reload;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      tick_q <= '0;
      line_q <= 1'b1;
    end else begin
      bits_q <= bits_d;
      tick_q <= tick_d;
      line_q <= line_d;
    end
  end

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BitsW'(FRAME_BITS))
    else $error("frame bit counter beyond frame length");

  a_idle_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> line_q)
    else $error("line not at mark while idle");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !busy && item_i.req && cfg_i.link_attached
    |=> (bits_q == BitsW'(FRAME_BITS)) && !line_q)
    else $error("accepted byte did not start a frame");

  a_bit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && busy && (tick_q != '0) |=> $stable(bits_q) && $stable(line_q))
    else $error("line changed inside a bit period");

endmodule

`default_nettype wire

// File: design/utx_outq.sv
// Result queue of the 8E1 transmitter: holds finished results until popped.
// Depends on utx_pkg for the result type and queue sizes.
`default_nettype none

module utx_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  utx_pkg::result_t res_i,
  output logic             res_ready_o,
  output logic             empty,
  input  logic             pop,
  output utx_pkg::result_t res_o
);

  utx_pkg::result_t          mem_q [utx_pkg::QDepth];
  logic [utx_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [utx_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [utx_pkg::QCntW-1:0] count_q, count_d;
  logic                      do_push, do_pop;

  assign res_ready_o = (count_q != utx_pkg::QCntW'(utx_pkg::QDepth));
  assign empty       = (count_q == '0);
  assign res_o       = mem_q[rd_ptr_q];
  assign do_push     = res_valid_i && res_ready_o;
  assign do_pop      = pop && !empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: design/uart_tx_even_parity_top.sv
// Top level of the 8E1 serial transmitter: configuration registers and the
// front queue, transmit engine and result queue. Depends on utx_pkg and the utx_* modules.
`default_nettype none

// Each pushed item is one tick of the bit timer, optionally offering a byte. The block
// takes one item per clock cycle while full is low and returns exactly one result per
// item, in order: the line level and busy flag as they stood before that tick, and
// whether the byte was offered to an idle engine; it is only taken if the link is attached.
// An item is registered in the input queue, passes the transmit engine, whose result is
// combinational, and is registered in the result queue, from which it can be popped;
// with pop held high the sustained rate is one item per cycle, set by the engine's
// update of timer, shifter and line register as each item passes. Frames are a low start
// bit, eight data bits LSB first, even parity and FRAME_BITS-10 high stop bits, each bit
// lasting bit_period ticks. Write configuration only while no results are outstanding.
module uart_tx_even_parity_top #(
  parameter int unsigned FRAME_BITS = 11,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          send_request_i,
  input  logic [utx_pkg::DataW-1:0]     send_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          line_level_o,
  output logic                          busy_res_o,
  output logic                          accepted_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utx_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [utx_pkg::PeriodW-1:0]   cfg_data_i
);

  utx_pkg::cfg_t    cfg_q, cfg_d;
  utx_pkg::item_t   item;
  utx_pkg::result_t eng_res, out_res;
  logic             item_valid, item_ready;
  logic             res_valid, res_ready;
  logic             cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (utx_pkg::cfg_reg_e'(cfg_index_i))
        utx_pkg::CfgBitPeriod:    cfg_d.bit_period    = cfg_data_i;
        utx_pkg::CfgLinkAttached: cfg_d.link_attached = cfg_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period    <= utx_pkg::PeriodReset;
      cfg_q.link_attached <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  utx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .send_request_i (send_request_i),
    .send_byte_i    (send_byte_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_ready_i   (item_ready)
  );

  utx_engine #(
    .FRAME_BITS (FRAME_BITS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_valid_o  (res_valid),
    .res_o        (eng_res),
    .res_ready_i  (res_ready)
  );

  utx_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (eng_res),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .res_o       (out_res)
  );

  assign line_level_o = out_res.line;
  assign busy_res_o   = out_res.busy;
  assign accepted_o   = out_res.accepted;

endmodule

`default_nettype wire
